[rtl/core/rrf_pkg.sv]
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types and constants for the resp reply framer: reply kinds, status
// codes, parser phases, protocol characters and the result record.
// ----------------------------------------------------------------------------
package rrf_pkg;

  localparam int LEN_W           = 32;
  localparam int CNT_W           = 32;
  localparam int LENGTH_BITS_DEF = 32;

  localparam logic [LEN_W-1:0] MAX_REPLY_RST = 32'd67108864;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [2:0] {
    KIND_SIMPLE  = 3'd0,
    KIND_ERROR   = 3'd1,
    KIND_INTEGER = 3'd2,
    KIND_BULK    = 3'd3,
    KIND_NIL     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_MALFORMED   = 2'd1,
    ST_TOO_LONG    = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LINE = 2'd1,
    PH_HEAD = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    kind_t            kind;
    status_t          status;
    logic             ok;
  } rrf_result_t;

endpackage

[rtl/core/rrf_in_stage.sv]
// ----------------------------------------------------------------------------
// rrf_in_stage
// Input register for reply bytes; takes a new transaction whenever the held
// byte moves on to the parser or the register is empty.
// ----------------------------------------------------------------------------
module rrf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_stall,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);
  import rrf_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       take;

  assign in_stall = s1_valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte_r <= in_data_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

[rtl/core/rrf_parser.sv]
// ----------------------------------------------------------------------------
// rrf_parser
// Frame state and per-byte update: type byte, line scan, bulk length header
// and bulk data count, plus the length limit register.
// ----------------------------------------------------------------------------
module rrf_parser #(
  parameter int LENGTH_BITS = rrf_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [rrf_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       step,
  input  logic [7:0]                 byte_in,
  output logic                       emit,
  output rrf_pkg::rrf_result_t       res
);
  import rrf_pkg::*;

  localparam int VW = LENGTH_BITS + 4;
  localparam int TW = CNT_W + 2;

  logic [LEN_W-1:0]       max_r;
  phase_t                 phase_r, phase_nxt;
  kind_t                  type_r, type_nxt;
  logic [CNT_W-1:0]       seen_r, seen_nxt;
  logic                   cr_r, cr_nxt;
  logic [LENGTH_BITS-1:0] lv_r, lv_nxt;
  logic                   neg_r, neg_nxt;
  logic                   dig_r, dig_nxt;
  logic                   bad_r, bad_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;

  logic [CNT_W-1:0]       seen_inc;
  logic [VW-1:0]          lv_x;
  logic [VW-1:0]          lv_mul;
  logic [TW-1:0]          total;
  logic [CNT_W-1:0]       rem_dec;
  logic                   is_digit;
  logic [LEN_W-1:0]       len_c;
  kind_t                  kind_c;
  status_t                st_c;
  logic                   emit_c;

  assign seen_inc = (seen_r == {CNT_W{1'b1}}) ? seen_r : seen_r + 1'b1;
  assign is_digit = (byte_in inside {[CH_0:CH_9]});
  assign lv_x     = VW'(lv_r);
  assign lv_mul   = (lv_x << 3) + (lv_x << 1) + VW'(4'(byte_in - CH_0));
  assign total    = TW'(seen_inc) + TW'(lv_r) + TW'(2);
  assign rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

  // next frame state and result
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    seen_nxt  = seen_inc;
    cr_nxt    = cr_r;
    lv_nxt    = lv_r;
    neg_nxt   = neg_r;
    dig_nxt   = dig_r;
    bad_nxt   = bad_r;
    rem_nxt   = rem_r;
    emit_c    = 1'b0;
    len_c     = seen_inc;
    kind_c    = KIND_BULK;
    st_c      = ST_DONE;
    case (phase_r)
      PH_TYPE: begin
        seen_nxt = CNT_W'(1);
        cr_nxt   = 1'b0;
        lv_nxt   = '0;
        neg_nxt  = 1'b0;
        dig_nxt  = 1'b0;
        bad_nxt  = 1'b0;
        rem_nxt  = '0;
        case (byte_in)
          CH_PLUS: begin
            type_nxt  = KIND_SIMPLE;
            phase_nxt = PH_LINE;
          end
          CH_MINUS: begin
            type_nxt  = KIND_ERROR;
            phase_nxt = PH_LINE;
          end
          CH_COLON: begin
            type_nxt  = KIND_INTEGER;
            phase_nxt = PH_LINE;
          end
          CH_DOLLAR: begin
            type_nxt  = KIND_BULK;
            phase_nxt = PH_HEAD;
          end
          default: begin
            emit_c = 1'b1;
            len_c  = LEN_W'(1);
            kind_c = KIND_SIMPLE;
            st_c   = ST_UNSUPPORTED;
          end
        endcase
      end
      PH_LINE: begin
        if (cr_r && byte_in == CH_LF) begin
          emit_c = 1'b1;
          kind_c = type_r;
        end else begin
          cr_nxt = (byte_in == CH_CR);
        end
      end
      PH_HEAD: begin
        if (cr_r && byte_in == CH_LF) begin
          if (bad_r || !dig_r) begin
            emit_c = 1'b1;
            st_c   = ST_MALFORMED;
          end else if (neg_r && lv_r == LENGTH_BITS'(1)) begin
            emit_c = 1'b1;
            kind_c = KIND_NIL;
          end else if (neg_r && lv_r != '0) begin
            emit_c = 1'b1;
            st_c   = ST_MALFORMED;
          end else if (total > TW'(max_r)) begin
            emit_c = 1'b1;
            st_c   = ST_TOO_LONG;
            len_c  = (total[TW-1:CNT_W] != '0) ? {LEN_W{1'b1}} : total[LEN_W-1:0];
          end else begin
            rem_nxt   = CNT_W'(lv_r) + CNT_W'(2);
            cr_nxt    = 1'b0;
            phase_nxt = PH_DATA;
          end
        end else begin
          if (cr_r) begin
            bad_nxt = 1'b1;
          end
          if (byte_in == CH_CR) begin
            cr_nxt = 1'b1;
          end else begin
            cr_nxt = 1'b0;
            if (byte_in == CH_MINUS && seen_inc == CNT_W'(2)) begin
              neg_nxt = 1'b1;
            end else if (is_digit) begin
              dig_nxt = 1'b1;
              lv_nxt  = (lv_mul[VW-1:LENGTH_BITS] != '0) ? {LENGTH_BITS{1'b1}}
                                                          : lv_mul[LENGTH_BITS-1:0];
            end else begin
              bad_nxt = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        if (rem_dec == '0) begin
          emit_c = 1'b1;
        end else begin
          rem_nxt = rem_dec;
        end
      end
      default: begin
        phase_nxt = PH_TYPE;
      end
    endcase
    if (emit_c) begin
      phase_nxt = PH_TYPE;
      type_nxt  = KIND_SIMPLE;
      seen_nxt  = '0;
      cr_nxt    = 1'b0;
      lv_nxt    = '0;
      neg_nxt   = 1'b0;
      dig_nxt   = 1'b0;
      bad_nxt   = 1'b0;
      rem_nxt   = '0;
    end
  end

  // result outputs
  always_comb begin
    emit       = step && emit_c;
    res.length = len_c;
    res.kind   = kind_c;
    res.status = st_c;
    res.ok     = (st_c == ST_DONE) && (kind_c != KIND_ERROR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= MAX_REPLY_RST;
      phase_r <= PH_TYPE;
      type_r  <= KIND_SIMPLE;
      seen_r  <= '0;
      cr_r    <= 1'b0;
      lv_r    <= '0;
      neg_r   <= 1'b0;
      dig_r   <= 1'b0;
      bad_r   <= 1'b0;
      rem_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (step) begin
        phase_r <= phase_nxt;
        type_r  <= type_nxt;
        seen_r  <= seen_nxt;
        cr_r    <= cr_nxt;
        lv_r    <= lv_nxt;
        neg_r   <= neg_nxt;
        dig_r   <= dig_nxt;
        bad_r   <= bad_nxt;
        rem_r   <= rem_nxt;
      end
    end
  end

  a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (rem_r != '0))
    else $error("bulk data phase with nothing left to count");

  a_type_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TYPE) |-> (!cr_r && !bad_r && !dig_r))
    else $error("frame state not cleared while waiting for type byte");

  // a saturated total may equal the largest limit
  a_too_long_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.status == ST_TOO_LONG) |-> (res.length > max_r || res.length == '1))
    else $error("too long reported within the limit");

endmodule

[rtl/core/rrf_out_stage.sv]
// ----------------------------------------------------------------------------
// rrf_out_stage
// Result register; holds a finished reply record until the receiver takes
// the transaction.
// ----------------------------------------------------------------------------
module rrf_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      emit,
  input  rrf_pkg::rrf_result_t      res,
  output logic                      ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rrf_pkg::LEN_W-1:0] out_reply_length,
  output logic [2:0]                out_reply_kind,
  output logic [1:0]                out_status,
  output logic                      out_reply_ok
);
  import rrf_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  rrf_result_t res_r;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_reply_length = res_r.length;
  assign out_reply_kind   = res_r.kind;
  assign out_status       = res_r.status;
  assign out_reply_ok     = res_r.ok;

endmodule

[rtl/core/resp_reply_framer_core.sv]
// ----------------------------------------------------------------------------
// resp_reply_framer_core
// Finds reply boundaries in a RESP2 reply byte stream and reports each reply.
//
// Input channel: one reply byte per transaction on in_data_byte, taken when
// in_valid is high and in_stall low. Output channel: one transaction per
// finished reply (length, kind, status, ok flag), taken when out_valid is
// high and out_stall low. Bytes that do not end a reply give no output.
// Throughput is one byte per cycle while out_stall holds no result. A byte is
// held in the input register and parsed from there; its reply, if any, goes
// through the result register to the output. Reset clears the frame state,
// empties both registers and loads the length limit with 64 MiB; cfg_wr_en
// writes a new limit, which the user must do only while idle (not enforced).
// While a result is held under out_stall the parser waits; at most one more
// byte is taken into the input register, and in_stall is high while it is full.
// ----------------------------------------------------------------------------
module resp_reply_framer_core #(
  parameter int LENGTH_BITS = rrf_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rrf_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rrf_pkg::LEN_W-1:0] out_reply_length,
  output logic [2:0]                out_reply_kind,
  output logic [1:0]                out_status,
  output logic                      out_reply_ok
);
  import rrf_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        adv;
  logic        ready;
  logic        emit;
  rrf_result_t res;

  assign adv = s1_valid && ready;

  rrf_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .adv          (adv),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte)
  );

  rrf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (adv),
    .byte_in     (s1_byte),
    .emit        (emit),
    .res         (res)
  );

  rrf_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit             (emit),
    .res              (res),
    .ready            (ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_length (out_reply_length),
    .out_reply_kind   (out_reply_kind),
    .out_status       (out_status),
    .out_reply_ok     (out_reply_ok)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !emit)
    else $error("held result overwritten");

endmodule

[tb/tb_resp_reply_framer_core.sv]
// ----------------------------------------------------------------------------
// tb_resp_reply_framer_core
// Self-checking bench for the resp reply framer. A queue of reply bytes feeds
// a clocked driver; a bit-accurate framing predictor runs on every accepted
// byte and queues the reply records it expects. A clocked monitor compares
// each output transaction field by field. The run walks through several
// length limits (minimum, maximum, small and reset value) with directed
// replies, random well-formed replies, broken headers and raw noise, with
// random idle bursts on both sides except in the final phase.
// ----------------------------------------------------------------------------
module tb_resp_reply_framer_core;
  import rrf_pkg::*;

  localparam int STUCK_LIMIT = 4000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LEN_W-1:0]  out_reply_length;
  logic [2:0]        out_reply_kind;
  logic [1:0]        out_status;
  logic              out_reply_ok;

  resp_reply_framer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_length (out_reply_length),
    .out_reply_kind   (out_reply_kind),
    .out_status       (out_status),
    .out_reply_ok     (out_reply_ok)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // framing predictor state
  logic [LEN_W-1:0] reply_limit = MAX_REPLY_RST;
  phase_t           framer_phase = PH_TYPE;
  kind_t            frame_kind = KIND_SIMPLE;
  logic [31:0]      frame_count = '0;
  logic             cr_seen = 1'b0;
  logic [31:0]      header_value = '0;
  logic             header_negative = 1'b0;
  logic             header_digit = 1'b0;
  logic             header_bad = 1'b0;
  logic [31:0]      data_left = '0;

  logic [7:0]       pending_bytes[$];
  rrf_result_t      expected_replies[$];
  rrf_result_t      want_reply;
  int unsigned      queued_total = 0;
  int unsigned      failures = 0;
  int unsigned      stuck_cycles = 0;
  int unsigned      send_gap = 0;
  int unsigned      recv_hold = 0;
  bit               idling_on = 1'b1;

  function automatic void clear_frame();
    framer_phase    = PH_TYPE;
    frame_kind      = KIND_SIMPLE;
    frame_count     = '0;
    cr_seen         = 1'b0;
    header_value    = '0;
    header_negative = 1'b0;
    header_digit    = 1'b0;
    header_bad      = 1'b0;
    data_left       = '0;
  endfunction

  function automatic void record_reply(input logic [63:0] len, input kind_t k,
                                       input status_t s);
    rrf_result_t r;
    r.length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
    r.kind   = k;
    r.status = s;
    r.ok     = (s == ST_DONE) && (k != KIND_ERROR);
    expected_replies.push_back(r);
    clear_frame();
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    logic [63:0] scaled;
    logic [63:0] total;
    if (framer_phase == PH_TYPE) begin
      clear_frame();
      frame_count = 32'd1;
      case (b)
        CH_PLUS:   frame_kind = KIND_SIMPLE;
        CH_MINUS:  frame_kind = KIND_ERROR;
        CH_COLON:  frame_kind = KIND_INTEGER;
        CH_DOLLAR: frame_kind = KIND_BULK;
        default: begin
          record_reply(64'd1, KIND_SIMPLE, ST_UNSUPPORTED);
          return;
        end
      endcase
      framer_phase = (frame_kind == KIND_BULK) ? PH_HEAD : PH_LINE;
      return;
    end
    if (frame_count != 32'hFFFF_FFFF)
      frame_count = frame_count + 32'd1;
    case (framer_phase)
      PH_LINE: begin
        if (cr_seen && b == CH_LF)
          record_reply({32'd0, frame_count}, frame_kind, ST_DONE);
        else
          cr_seen = (b == CH_CR);
      end
      PH_HEAD: begin
        if (cr_seen && b == CH_LF) begin
          total = {32'd0, frame_count} + {32'd0, header_value} + 64'd2;
          if (header_bad || !header_digit)
            record_reply({32'd0, frame_count}, KIND_BULK, ST_MALFORMED);
          else if (header_negative && header_value == 32'd1)
            record_reply({32'd0, frame_count}, KIND_NIL, ST_DONE);
          else if (header_negative && header_value != 32'd0)
            record_reply({32'd0, frame_count}, KIND_BULK, ST_MALFORMED);
          else if (total > {32'd0, reply_limit})
            record_reply(total, KIND_BULK, ST_TOO_LONG);
          else begin
            data_left    = header_value + 32'd2;
            cr_seen      = 1'b0;
            framer_phase = PH_DATA;
          end
        end else begin
          if (cr_seen)
            header_bad = 1'b1;
          if (b == CH_CR) begin
            cr_seen = 1'b1;
          end else begin
            cr_seen = 1'b0;
            if (b == CH_MINUS && frame_count == 32'd2) begin
              header_negative = 1'b1;
            end else if (b >= CH_0 && b <= CH_9) begin
              header_digit = 1'b1;
              scaled = {32'd0, header_value} * 64'd10 + {56'd0, b - CH_0};
              header_value = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
            end else begin
              header_bad = 1'b1;
            end
          end
        end
      end
      default: begin
        if (data_left != 32'd0)
          data_left = data_left - 32'd1;
        if (data_left == 32'd0)
          record_reply({32'd0, frame_count}, KIND_BULK, ST_DONE);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'h00;
      send_gap     <= 0;
    end else begin
      if (in_valid && !in_stall)
        frame_byte(in_data_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid     <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
          if (idling_on && $urandom_range(0, 11) == 0)
            send_gap <= $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply transaction: length %0d kind %0d status %0d ok %0d",
                 out_reply_length, out_reply_kind, out_status, out_reply_ok);
          failures++;
        end else begin
          want_reply = expected_replies.pop_front();
          if (out_reply_length !== want_reply.length) begin
            $error("reply_length expected %0d actual %0d", want_reply.length,
                   out_reply_length);
            failures++;
          end
          if (out_reply_kind !== want_reply.kind) begin
            $error("reply_kind expected %0d actual %0d", want_reply.kind, out_reply_kind);
            failures++;
          end
          if (out_status !== want_reply.status) begin
            $error("status expected %0d actual %0d", want_reply.status, out_status);
            failures++;
          end
          if (out_reply_ok !== want_reply.ok) begin
            $error("reply_ok expected %0d actual %0d", want_reply.ok, out_reply_ok);
            failures++;
          end
        end
      end
      if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idling_on && $urandom_range(0, 11) == 0)
          recv_hold <= $urandom_range(1, 18);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i]);
  endtask

  task automatic queue_bulk(input int unsigned len);
    queue_text($sformatf("$%0d\015\n", len));
    for (int unsigned i = 0; i < len + 2; i++)
      queue_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_line();
    int unsigned n;
    case ($urandom_range(0, 2))
      0:       queue_byte(CH_PLUS);
      1:       queue_byte(CH_MINUS);
      default: queue_byte(CH_COLON);
    endcase
    n = $urandom_range(0, 12);
    for (int unsigned i = 0; i < n; i++)
      queue_byte(8'($urandom_range(0, 255)));
    queue_text("\015\n");
  endtask

  task automatic queue_bad_header();
    case ($urandom_range(0, 6))
      0:       queue_text("$\015\n");
      1:       queue_text("$-\015\n");
      2:       queue_text($sformatf("$-%0d\015\n", $urandom_range(2, 999)));
      3:       queue_text("$1-2\015\n");
      4:       queue_text("$4a\015\n");
      5:       queue_text("$3\015z\015\n");
      default: queue_text("$--1\015\n");
    endcase
  endtask

  task automatic queue_random_replies(input int unsigned byte_budget);
    int unsigned start_count;
    int unsigned pick;
    logic [7:0]  junk;
    start_count = queued_total;
    while (queued_total - start_count < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_bulk($urandom_range(0, 24));
      end else if (pick < 60) begin
        queue_line();
      end else if (pick < 67) begin
        queue_text("$-1\015\n");
      end else if (pick < 70) begin
        queue_text("$-0\015\n");
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        queue_bad_header();
      end else if (pick < 87) begin
        if ($urandom_range(0, 2) == 0)
          queue_text("$99999999999\015\n");
        else
          queue_text($sformatf("$%0d\015\n", reply_limit));
      end else if (pick < 95) begin
        junk = 8'($urandom_range(0, 255));
        while (junk == CH_PLUS || junk == CH_MINUS || junk == CH_COLON || junk == CH_DOLLAR)
          junk = 8'($urandom_range(0, 255));
        queue_byte(junk);
      end else begin
        repeat ($urandom_range(1, 6))
          queue_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // wait until every queued byte is taken and every reply has been seen
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    reply_limit = value;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: type byte extremes, every reply type and the header corner cases
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_text("+OK\015\n");
    queue_text("-E\015\n");
    queue_text(":7\015\n");
    queue_text("$2\015\nab\015\n");
    queue_text("$-1\015\n");
    queue_text("$-0\015\n\015\n");
    queue_text("$-3\015\n");
    queue_text("$\015\n");
    queue_text("$-\015\n");
    queue_text("$1\015x\015\n");
    queue_text("$99999999999\015\n");
    settle();

    write_limit(32'd1);
    queue_random_replies(120);
    settle();

    write_limit(32'hFFFF_FFFF);
    queue_text("$4294967295\015\n");
    queue_random_replies(180);
    settle();

    write_limit(32'd20);
    queue_bulk(13);
    queue_text("$14\015\n");
    queue_random_replies(180);
    settle();

    write_limit($urandom_range(16, 300));
    queue_random_replies(180);
    settle();

    // final phase runs without idle bursts
    idling_on = 1'b0;
    write_limit(MAX_REPLY_RST);
    queue_random_replies(150);
    settle();

    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
